>>> design/stse_pkg.sv
// ----------------------------------------------------------------------------
// stse_pkg: shared types and constants of the timer slot engine
// slot word layout, channel field widths, operation codes and the
// constants of the millisecond to tick conversion
// ----------------------------------------------------------------------------
package stse_pkg;

  // table depth and result limit per operation
  localparam int NumSlots = 8;
  localparam int MaxRes   = 8;
  localparam int FireW    = $clog2(MaxRes + 1);
  localparam int EvIdxW   = (MaxRes > 1) ? $clog2(MaxRes) : 1;

  // field widths
  localparam int OpW    = 2;
  localparam int MsgW   = 8;
  localparam int RcvW   = 7;
  localparam int DelayW = 32;
  localparam int RunW   = 32;
  localparam int CdW    = 29;

  // delay conversion: short delays get a fixed count, others delay/10+1
  localparam int unsigned ArmMinMs    = 20;
  localparam int unsigned ArmMinTicks = 2;
  // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
  localparam logic [DelayW-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int RecipShift = 35;

  typedef enum logic [OpW-1:0] {
    OpTick   = 2'd0,
    OpArm    = 2'd1,
    OpCancel = 2'd2,
    OpSleep  = 2'd3
  } op_e;

  // move applied to every cell of the chain alike in the same cycle
  typedef enum logic [1:0] {
    CellHold  = 2'd0,
    CellRight = 2'd1,
    CellLeft  = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       wr_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [MsgW-1:0] msg;
    logic [RcvW-1:0] rcv;
    logic [CdW-1:0]  cd;
  } slot_t;

endpackage

>>> design/stse_if.sv
// ----------------------------------------------------------------------------
// stse_if: valid/ready channels of the timer slot engine
// one interface for the operation words and one for the result words
// ----------------------------------------------------------------------------
interface stse_in_if import stse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [MsgW-1:0]   message;
  logic [RcvW-1:0]   receiver;
  logic [DelayW-1:0] delay_ms;
  logic [RunW-1:0]   slept_ticks;

  modport source (output valid, op, message, receiver, delay_ms, slept_ticks,
                  input ready);
  modport sink (input valid, op, message, receiver, delay_ms, slept_ticks,
                output ready);
endinterface

interface stse_out_if import stse_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic            status;
  logic [MsgW-1:0] event_message;
  logic [RcvW-1:0] event_receiver;
  logic            last;
  logic [RunW-1:0] runtime_ticks;
  logic [CdW-1:0]  shortest_remaining;

  modport source (output valid, kind, status, event_message, event_receiver, last,
                  runtime_ticks, shortest_remaining, input ready);
  modport sink (input valid, kind, status, event_message, event_receiver, last,
                runtime_ticks, shortest_remaining, output ready);
endinterface

>>> design/stse_cell.sv
// ----------------------------------------------------------------------------
// stse_cell: one timer slot of the chain
// holds message, receiver and countdown; takes its left neighbor on an
// insert, its right neighbor on a pass step, or the write-back word when
// the pass addresses this cell
// ----------------------------------------------------------------------------
module stse_cell import stse_pkg::*; #(
  parameter int SLOTS = NumSlots,
  parameter int IDX   = 0,
  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk_i,
  input  cell_ctrl_t    ctrl_i,
  input  logic [IW-1:0] wr_pos_i,
  input  slot_t         left_i,
  input  slot_t         right_i,
  input  slot_t         wr_data_i,
  output slot_t         slot_o
);

  slot_t slot_q;
  slot_t slot_d;

  // neighbor selection
  always_comb begin
    slot_d = slot_q;
    unique case (ctrl_i.mode)
      CellRight: slot_d = left_i;
      CellLeft: begin
        if (ctrl_i.wr_en && (wr_pos_i == IW'(IDX))) begin
          slot_d = wr_data_i;
        end else begin
          slot_d = right_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

>>> design/stse_ticks.sv
// ----------------------------------------------------------------------------
// stse_ticks: millisecond delay to 10 ms tick count
// delay/10 by reciprocal multiply, product registered, then +1; delays up
// to the short limit map to the fixed minimum
// ----------------------------------------------------------------------------
module stse_ticks import stse_pkg::*; (
  input  logic              clk_i,
  input  logic [DelayW-1:0] delay_i,
  output logic [CdW-1:0]    ticks_o
);

  localparam int ProdW = 2 * DelayW;

  logic [ProdW-1:0] prod_q;
  logic             long_q;

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(delay_i) * ProdW'(Recip10);
    long_q <= delay_i > DelayW'(ArmMinMs);
  end

  // quotient plus one, or the minimum count
  assign ticks_o = long_q ? (prod_q[RecipShift +: CdW] + CdW'(1)) : CdW'(ArmMinTicks);

endmodule

>>> design/software_timer_slot_engine.sv
// ----------------------------------------------------------------------------
// software_timer_slot_engine: ordered table of one-shot timer slots
// Sequence: arm passes the multiply and insert states, sleep goes to emit,
//   tick and cancel pass the slots in use (one per cycle through the chain
//   head), then one result word per cycle into a free output register.
// Throughput: one operation at a time; a new word is taken once the last
//   result word sits in the output register.
// Reset: table empty, runtime count zero; no clearing pass.
// ----------------------------------------------------------------------------
module software_timer_slot_engine import stse_pkg::*; #(
  parameter int SLOTS = NumSlots
) (
  input  logic clk_i,
  input  logic rst_ni,
  stse_in_if.sink    in_i,
  stse_out_if.source out_o
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StArmMul,
    StArmIns,
    StPass,
    StEmit
  } state_e;

  state_e             state_q;
  op_e                op_q;
  logic [MsgW-1:0]    msg_q;
  logic [RcvW-1:0]    rcv_q;
  logic [DelayW-1:0]  delay_q;
  logic [RunW-1:0]    runtime_q;
  logic [CdW-1:0]     sh_q;
  logic [CdW-1:0]     sh_acc_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      rem_q;
  logic [CW-1:0]      kept_q;
  logic [FireW-1:0]   fired_q;
  logic [EvIdxW-1:0]  ei_q;
  logic               hit_q;
  logic               st_q;
  logic [MsgW-1:0]    ev_msg_q [MaxRes];
  logic [RcvW-1:0]    ev_rcv_q [MaxRes];

  logic               out_valid_q;
  logic               out_kind_q;
  logic               out_status_q;
  logic [MsgW-1:0]    out_msg_q;
  logic [RcvW-1:0]    out_rcv_q;
  logic               out_last_q;
  logic [RunW-1:0]    out_run_q;
  logic [CdW-1:0]     out_sh_q;

  slot_t              cell_q [SLOTS];
  slot_t              new_slot;
  slot_t              head;
  slot_t              proc_slot;
  cell_ctrl_t         cell_ctrl;
  logic [CW-1:0]      wr_sum;
  logic [IW-1:0]      wr_pos;
  logic [CdW-1:0]     ticks;
  logic               full;
  logic               due;
  logic               drop;
  logic               in_fire;
  logic               out_free;
  logic               have_ev;
  logic               emit_last;

  // delay conversion for arm
  stse_ticks u_ticks (
    .clk_i   (clk_i),
    .delay_i (delay_q),
    .ticks_o (ticks)
  );

  // chain of slot cells, head at index zero
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_t left_w;
    slot_t right_w;
    if (i == 0) begin : g_head
      assign left_w = new_slot;
    end else begin : g_body
      assign left_w = cell_q[i-1];
    end
    if (i == SLOTS - 1) begin : g_tail
      assign right_w = proc_slot;
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end
    stse_cell #(
      .SLOTS (SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .wr_pos_i  (wr_pos),
      .left_i    (left_w),
      .right_i   (right_w),
      .wr_data_i (proc_slot),
      .slot_o    (cell_q[i])
    );
  end

  assign full     = count_q == CW'(SLOTS);
  assign new_slot = '{msg: msg_q, rcv: rcv_q, cd: ticks};
  assign head     = cell_q[0];

  // head word of the pass: fire, match or decrement
  always_comb begin
    due       = head.cd <= CdW'(1);
    proc_slot = head;
    drop      = 1'b0;
    if (op_q == OpTick) begin
      drop = due && (fired_q < FireW'(MaxRes));
      if (!due) begin
        proc_slot.cd = head.cd - CdW'(1);
      end
    end else begin
      drop = !hit_q && (head.rcv == rcv_q) && (head.msg == msg_q);
    end
  end

  // kept word goes behind the unvisited words and those kept so far
  assign wr_sum = rem_q - CW'(1) + kept_q;
  assign wr_pos = wr_sum[IW-1:0];

  // chain control
  always_comb begin
    cell_ctrl.mode  = CellHold;
    cell_ctrl.wr_en = 1'b0;
    if ((state_q == StPass) && (rem_q != '0)) begin
      cell_ctrl.mode  = CellLeft;
      cell_ctrl.wr_en = !drop;
    end else if ((state_q == StArmIns) && !full) begin
      cell_ctrl.mode = CellRight;
    end
  end

  // handshakes and result selection
  assign in_i.ready = state_q == StIdle;
  assign in_fire    = in_i.valid && (state_q == StIdle);
  assign out_free   = !out_valid_q || out_o.ready;
  assign have_ev    = (op_q == OpTick) && (fired_q != '0);
  assign emit_last  = have_ev ? ((FireW'(ei_q) + FireW'(1)) == fired_q) : 1'b1;

  // sequencer, runtime, table bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      runtime_q   <= '0;
      sh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StEmit) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            op_q     <= op_e'(in_i.op);
            msg_q    <= in_i.message;
            rcv_q    <= in_i.receiver;
            delay_q  <= in_i.delay_ms;
            rem_q    <= count_q;
            kept_q   <= '0;
            fired_q  <= '0;
            hit_q    <= 1'b0;
            sh_acc_q <= '0;
            st_q     <= 1'b0;
            ei_q     <= '0;
            unique case (op_e'(in_i.op))
              OpTick: begin
                runtime_q <= runtime_q + RunW'(1);
                state_q   <= StPass;
              end
              OpArm:    state_q <= StArmMul;
              OpCancel: state_q <= StPass;
              default: begin
                runtime_q <= runtime_q + in_i.slept_ticks;
                state_q   <= StEmit;
              end
            endcase
          end
        end

        StArmMul: state_q <= StArmIns;

        StArmIns: begin
          if (full) begin
            st_q <= 1'b1;
          end else begin
            count_q <= count_q + CW'(1);
            if ((sh_q == '0) || (ticks < sh_q)) begin
              sh_q <= ticks;
            end
          end
          state_q <= StEmit;
        end

        StPass: begin
          if (rem_q == '0) begin
            count_q <= kept_q;
            sh_q    <= sh_acc_q;
            st_q    <= (op_q == OpCancel) && !hit_q;
            state_q <= StEmit;
          end else begin
            rem_q <= rem_q - CW'(1);
            if (drop) begin
              if (op_q == OpTick) begin
                ev_msg_q[fired_q[EvIdxW-1:0]] <= head.msg;
                ev_rcv_q[fired_q[EvIdxW-1:0]] <= head.rcv;
                fired_q <= fired_q + FireW'(1);
              end else begin
                hit_q <= 1'b1;
              end
            end else begin
              kept_q <= kept_q + CW'(1);
              if ((sh_acc_q == '0) || (proc_slot.cd < sh_acc_q)) begin
                sh_acc_q <= proc_slot.cd;
              end
            end
          end
        end

        StEmit: begin
          if (out_free) begin
            out_kind_q   <= !have_ev;
            out_status_q <= have_ev ? 1'b0 : st_q;
            out_msg_q    <= have_ev ? ev_msg_q[ei_q] : '0;
            out_rcv_q    <= have_ev ? ev_rcv_q[ei_q] : '0;
            out_last_q   <= emit_last;
            out_run_q    <= runtime_q;
            out_sh_q     <= sh_q;
            if (emit_last) begin
              state_q <= StIdle;
            end else begin
              ei_q <= ei_q + EvIdxW'(1);
            end
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.kind               = out_kind_q;
  assign out_o.status             = out_status_q;
  assign out_o.event_message      = out_msg_q;
  assign out_o.event_receiver     = out_rcv_q;
  assign out_o.last               = out_last_q;
  assign out_o.runtime_ticks      = out_run_q;
  assign out_o.shortest_remaining = out_sh_q;

endmodule
